// ----- rtl/jse_pkg.sv -----
// Package for the JSON string escaper.
// Holds the burst type passed from front to back end, character codes
// and the hex digit helper. No dependencies.
package jse_pkg;

  // Queue between front and back end.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  // Largest burst that one input byte can cause.
  localparam int unsigned MaxBurst = 8;

  // Held prefix codes.
  localparam logic [1:0] HeldNone = 2'd0;
  localparam logic [1:0] HeldE2   = 2'd1;
  localparam logic [1:0] HeldE280 = 2'd2;

  // Character codes.
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChBs     = 8'h08;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChTwo    = 8'h32;
  localparam logic [7:0] ChEight  = 8'h38;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] Utf8Lead = 8'hE2;
  localparam logic [7:0] Utf8Mid  = 8'h80;
  localparam logic [7:0] Utf8Ls   = 8'hA8;
  localparam logic [7:0] Utf8Ps   = 8'hA9;

  // One burst of output text caused by a single input byte.
  typedef struct packed {
    logic [MaxBurst-1:0][7:0] bytes;
    logic [3:0]               count;  // 1 to 8
    logic                     last;   // input had message_last set
  } burst_t;

  // Lowercase hex digit for one nibble.
  function automatic logic [7:0] hex_lc(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = ChZero + {4'd0, nib};
    end else begin
      r = 8'h57 + {4'd0, nib};
    end
    return r;
  endfunction

endpackage

// ----- rtl/jse_front.sv -----
// Front end of the JSON string escaper: accepts raw bytes, tracks the
// held UTF-8 prefix and builds the burst of output bytes. Uses jse_pkg.
module jse_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      in_byte_i,
  input  logic            message_last_i,
  input  logic            q_full_i,
  output logic            push_o,
  output jse_pkg::burst_t burst_o
);
  import jse_pkg::*;

  logic [1:0] held_q, held_d;
  logic [1:0] h;
  logic       accept;
  logic [3:0] n;
  logic [MaxBurst-1:0][7:0] b;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Classify the byte and lay out the bytes it causes.
  always_comb begin
    b      = '0;
    n      = 4'd0;
    h      = (held_q == HeldE2 || held_q == HeldE280) ? held_q : HeldNone;
    held_d = HeldNone;
    if (h == HeldE2 && in_byte_i == Utf8Mid) begin
      held_d = HeldE280;
    end else if (h == HeldE280 && (in_byte_i == Utf8Ls || in_byte_i == Utf8Ps)) begin
      b[n[2:0]] = ChBslash; n = n + 4'd1;
      b[n[2:0]] = ChLowU;   n = n + 4'd1;
      b[n[2:0]] = ChTwo;    n = n + 4'd1;
      b[n[2:0]] = ChZero;   n = n + 4'd1;
      b[n[2:0]] = ChTwo;    n = n + 4'd1;
      b[n[2:0]] = (in_byte_i == Utf8Ls) ? ChEight : ChNine;
      n = n + 4'd1;
    end else begin
      // The prefix is broken: held bytes go out raw first.
      if (h == HeldE2 || h == HeldE280) begin
        b[n[2:0]] = Utf8Lead; n = n + 4'd1;
      end
      if (h == HeldE280) begin
        b[n[2:0]] = Utf8Mid; n = n + 4'd1;
      end
      case (in_byte_i)
        ChQuote, ChBslash: begin
          b[n[2:0]] = ChBslash;  n = n + 4'd1;
          b[n[2:0]] = in_byte_i; n = n + 4'd1;
        end
        ChBs: begin
          b[n[2:0]] = ChBslash; n = n + 4'd1;
          b[n[2:0]] = ChLowB;   n = n + 4'd1;
        end
        ChFf: begin
          b[n[2:0]] = ChBslash; n = n + 4'd1;
          b[n[2:0]] = ChLowF;   n = n + 4'd1;
        end
        ChLf: begin
          b[n[2:0]] = ChBslash; n = n + 4'd1;
          b[n[2:0]] = ChLowN;   n = n + 4'd1;
        end
        ChCr: begin
          b[n[2:0]] = ChBslash; n = n + 4'd1;
          b[n[2:0]] = ChLowR;   n = n + 4'd1;
        end
        ChTab: begin
          b[n[2:0]] = ChBslash; n = n + 4'd1;
          b[n[2:0]] = ChLowT;   n = n + 4'd1;
        end
        default: begin
          if (in_byte_i < ChSpace) begin
            b[n[2:0]] = ChBslash;              n = n + 4'd1;
            b[n[2:0]] = ChLowU;                n = n + 4'd1;
            b[n[2:0]] = ChZero;                n = n + 4'd1;
            b[n[2:0]] = ChZero;                n = n + 4'd1;
            b[n[2:0]] = hex_lc(in_byte_i[7:4]); n = n + 4'd1;
            b[n[2:0]] = hex_lc(in_byte_i[3:0]); n = n + 4'd1;
          end else if (in_byte_i == Utf8Lead) begin
            held_d = HeldE2;
          end else begin
            b[n[2:0]] = in_byte_i; n = n + 4'd1;
          end
        end
      endcase
    end
    // At the end of the message anything still held goes out raw.
    if (message_last_i) begin
      if (held_d == HeldE2 || held_d == HeldE280) begin
        b[n[2:0]] = Utf8Lead; n = n + 4'd1;
      end
      if (held_d == HeldE280) begin
        b[n[2:0]] = Utf8Mid; n = n + 4'd1;
      end
      held_d = HeldNone;
    end
  end

  assign push_o        = accept && (n != 4'd0);
  assign burst_o.bytes = b;
  assign burst_o.count = n;
  assign burst_o.last  = message_last_i;

  // Held prefix state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= HeldNone;
    end else if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

// ----- rtl/jse_queue.sv -----
// Short queue of bursts between the front and back end of the escaper.
// Uses jse_pkg for the burst type and depth.
module jse_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  jse_pkg::burst_t push_data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output jse_pkg::burst_t head_o
);
  import jse_pkg::*;

  burst_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, rd_q;
  logic [QCntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

// ----- rtl/jse_back.sv -----
// Back end of the escaper: steps through the head burst one byte per
// accepted output and pops it after its last byte. Uses jse_pkg.
module jse_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  jse_pkg::burst_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            message_end_o
);
  import jse_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic       fire;
  logic       done;

  assign out_valid_o   = !empty_i;
  assign fire          = out_valid_o && !out_stall_i;
  assign done          = ({1'b0, idx_q} == (head_i.count - 4'd1));
  assign out_byte_o    = head_i.bytes[idx_q];
  assign run_last_o    = done;
  assign message_end_o = done && head_i.last;
  assign pop_o         = fire && done;

  // Byte index within the current burst.
  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = done ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ----- rtl/json_string_escaper.sv -----
// JSON string escaper top level: front end, burst queue, back end.
// An accepted byte that causes output is queued, then shown from the head.
// Throughput: one input byte per cycle while each causes one output byte and
// output is not stalled; a longer burst holds the back end until it is all
// taken, then the two-entry queue fills and stalls input. Reset clears the
// held prefix, the queue and the byte index. Depends on jse_pkg.
module json_string_escaper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       message_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       message_end_o
);
  import jse_pkg::*;

  logic   q_full, q_empty, push, pop;
  burst_t burst, head;

  jse_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .message_last_i (message_last_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .burst_o        (burst)
  );

  jse_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (burst),
    .pop_i       (pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  jse_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .message_end_o (message_end_o)
  );

endmodule
